// ===== sv/lps_pkg.sv =====
`default_nettype none
package lps_pkg;

  localparam int unsigned STAMP_W   = 16;
  localparam int unsigned RND_W     = 31;
  localparam int unsigned ID_OUT_W  = 5;
  localparam int unsigned SUM_OUT_W = 13;

  typedef enum logic [1:0] {
    REQ_READY  = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_RESCHED = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_SUM,
    ST_MOD,
    ST_WALK,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== sv/lps_if.sv =====
`default_nettype none
interface lps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  proc_id;
  logic [7:0]  tickets;
  logic [30:0] random_value;
  logic        current_runnable;

  modport source (output valid, req_type, proc_id, tickets, random_value, current_runnable,
                  input ready);
  modport sink (input valid, req_type, proc_id, tickets, random_value, current_runnable,
                output ready);
endinterface

interface lps_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  chosen_id;
  logic [4:0]  previous_id;
  logic [12:0] ticket_sum;
  logic [1:0]  status;

  modport source (output valid, chosen_id, previous_id, ticket_sum, status, input ready);
  modport sink (input valid, chosen_id, previous_id, ticket_sum, status, output ready);
endinterface
`default_nettype wire

// ===== sv/lps_ram.sv =====
`default_nettype none
module lps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/lottery_process_scheduler_unit.sv =====
// make ready, remove and unknown requests: result valid in the cycle after acceptance
// reschedule: running slot rejoins if needed, a sweep sums the tickets, the random
// value is taken modulo the sum, then 1..NUM_PROCS walk rounds; none when the sum is 0
// each sweep reads the slot table through the single ram read port, one slot a cycle
// one request at a time; a new request is taken only as the previous result leaves
// reset: ready set empty, running slot 0, stamp counter 0; table contents undefined
`default_nettype none
module lottery_process_scheduler_unit #(
  parameter int unsigned NUM_PROCS   = 32,
  parameter int unsigned TICKET_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lps_req_if.sink    req_i,
  lps_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(NUM_PROCS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned SUM_W = $clog2(NUM_PROCS * ((1 << TICKET_BITS) - 1) + 1);
  localparam int unsigned REM_W = SUM_W + 1;
  localparam int unsigned ENT_W = TICKET_BITS + lps_pkg::STAMP_W;
  localparam int unsigned KEY_W = ENT_W + IDX_W;
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_PROCS);

  lps_pkg::state_e state_q, state_d;

  logic [NUM_PROCS-1:0]         flags_q, flags_d;
  logic [lps_pkg::STAMP_W-1:0]  stamp_q, stamp_d;
  logic [IDX_W-1:0]             running_q, running_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic                         any_q, any_d;
  logic [lps_pkg::RND_W-1:0]    rnd_q, rnd_d;
  logic [REM_W-1:0]             rem_q, rem_d;
  logic [4:0]                   mod_cnt_q, mod_cnt_d;
  logic [KEY_W-1:0]             best_q, best_d, bound_q, bound_d;
  logic                         found_q, found_d, first_q, first_d;
  logic [IDX_W-1:0]             chosen_q, chosen_d;
  logic [lps_pkg::ID_OUT_W-1:0] prev_q, prev_d;

  logic                         out_valid_q, out_valid_d;
  logic [lps_pkg::ID_OUT_W-1:0] out_chosen_q, out_chosen_d;
  logic [lps_pkg::ID_OUT_W-1:0] out_prev_q, out_prev_d;
  logic [lps_pkg::SUM_OUT_W-1:0] out_sum_q, out_sum_d;
  logic [1:0]                   out_status_q, out_status_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic                        req_ready, accept, sweep_done, in_range;
  logic [31:0]                 pid32, run32, sum32, chosen32;
  logic [15:0]                 tk16;
  logic [IDX_W-1:0]            pid_idx;
  logic [TICKET_BITS-1:0]      tk, rd_tk, best_tk;
  logic [lps_pkg::STAMP_W-1:0] rd_age;
  logic [KEY_W-1:0]            rd_key;
  logic                        rd_cand;
  logic [REM_W-1:0]            mod_t, best_tk_ext;

  lps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_PROCS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept      = req_i.valid && req_ready;
  assign req_i.ready = req_ready;
  assign pid32       = 32'(req_i.proc_id);
  assign pid_idx     = pid32[IDX_W-1:0];
  assign in_range    = pid32 < NUM_PROCS;
  assign tk16        = {8'd0, req_i.tickets};
  assign tk          = tk16[TICKET_BITS-1:0];
  assign run32       = 32'(running_q);
  assign sum32       = 32'(sum_q);
  assign chosen32    = 32'(chosen_q);
  assign sweep_done  = (cnt_q == N_CNT) && !pend_q;

  assign rd_tk   = ram_rdata[ENT_W-1:lps_pkg::STAMP_W];
  assign rd_age  = stamp_q - ram_rdata[lps_pkg::STAMP_W-1:0];
  assign rd_key  = {rd_tk, rd_age, ~idx_q};
  assign rd_cand = pend_q && flags_q[idx_q] && (first_q || (rd_key < bound_q))
                   && (!found_q || (rd_key > best_q));
  assign best_tk     = best_q[KEY_W-1:KEY_W-TICKET_BITS];
  assign best_tk_ext = REM_W'(best_tk);
  assign mod_t       = {rem_q[SUM_W-1:0], rnd_q[lps_pkg::RND_W-1]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lps_pkg::ST_IDLE: begin
        if (accept && (req_i.req_type == lps_pkg::REQ_RESCHED)) begin
          if (req_i.current_runnable && !flags_q[running_q]) begin
            state_d = lps_pkg::ST_RUN_RD;
          end else begin
            state_d = lps_pkg::ST_SUM;
          end
        end
      end
      lps_pkg::ST_RUN_RD: state_d = lps_pkg::ST_RUN_WR;
      lps_pkg::ST_RUN_WR: state_d = lps_pkg::ST_SUM;
      lps_pkg::ST_SUM: begin
        if (sweep_done) begin
          state_d = (sum_q == '0) ? lps_pkg::ST_DONE : lps_pkg::ST_MOD;
        end
      end
      lps_pkg::ST_MOD: begin
        if (mod_cnt_q == 5'(lps_pkg::RND_W - 1)) begin
          state_d = lps_pkg::ST_WALK;
        end
      end
      lps_pkg::ST_WALK: begin
        if (sweep_done && (!found_q || (rem_q < best_tk_ext))) begin
          state_d = lps_pkg::ST_DONE;
        end
      end
      lps_pkg::ST_DONE: state_d = lps_pkg::ST_IDLE;
      default: state_d = lps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    flags_d      = flags_q;
    stamp_d      = stamp_q;
    running_d    = running_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    idx_d        = idx_q;
    sum_d        = sum_q;
    any_d        = any_q;
    rnd_d        = rnd_q;
    rem_d        = rem_q;
    mod_cnt_d    = mod_cnt_q;
    best_d       = best_q;
    bound_d      = bound_q;
    found_d      = found_q;
    first_d      = first_q;
    chosen_d     = chosen_q;
    prev_d       = prev_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_chosen_d = out_chosen_q;
    out_prev_d   = out_prev_q;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = pid_idx;
    ram_wdata    = {tk, stamp_q};
    ram_raddr    = cnt_q[IDX_W-1:0];
    req_ready    = 1'b0;

    unique case (state_q)
      lps_pkg::ST_IDLE: begin
        req_ready = !out_valid_q || rsp_o.ready;
        if (accept) begin
          prev_d       = run32[lps_pkg::ID_OUT_W-1:0];
          rnd_d        = req_i.random_value;
          sum_d        = '0;
          any_d        = 1'b0;
          chosen_d     = '0;
          cnt_d        = '0;
          out_chosen_d = run32[lps_pkg::ID_OUT_W-1:0];
          out_prev_d   = run32[lps_pkg::ID_OUT_W-1:0];
          out_sum_d    = '0;
          out_status_d = lps_pkg::STAT_NOCHANGE;
          case (req_i.req_type)
            lps_pkg::REQ_READY: begin
              out_valid_d = 1'b1;
              if (in_range && !flags_q[pid_idx]) begin
                ram_we           = 1'b1;
                flags_d[pid_idx] = 1'b1;
                stamp_d          = stamp_q + 1'b1;
                out_status_d     = lps_pkg::STAT_DONE;
              end
            end
            lps_pkg::REQ_REMOVE: begin
              out_valid_d = 1'b1;
              if (in_range && flags_q[pid_idx]) begin
                flags_d[pid_idx] = 1'b0;
                out_status_d     = lps_pkg::STAT_DONE;
              end
            end
            lps_pkg::REQ_RESCHED: begin
              out_valid_d = out_valid_q && !rsp_o.ready;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      lps_pkg::ST_RUN_RD: begin
        ram_raddr = running_q;
      end
      lps_pkg::ST_RUN_WR: begin
        ram_we             = 1'b1;
        ram_waddr          = running_q;
        ram_wdata          = {rd_tk, stamp_q};
        flags_d[running_q] = 1'b1;
        stamp_d            = stamp_q + 1'b1;
      end
      lps_pkg::ST_SUM: begin
        if (cnt_q != N_CNT) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          idx_d  = cnt_q[IDX_W-1:0];
        end
        if (pend_q && flags_q[idx_q]) begin
          sum_d = sum_q + SUM_W'(rd_tk);
          any_d = 1'b1;
        end
        if (sweep_done) begin
          rem_d     = '0;
          mod_cnt_d = '0;
        end
      end
      lps_pkg::ST_MOD: begin
        rem_d     = (mod_t >= REM_W'(sum_q)) ? (mod_t - REM_W'(sum_q)) : mod_t;
        rnd_d     = {rnd_q[lps_pkg::RND_W-2:0], 1'b0};
        mod_cnt_d = mod_cnt_q + 1'b1;
        cnt_d     = '0;
        first_d   = 1'b1;
        found_d   = 1'b0;
      end
      lps_pkg::ST_WALK: begin
        if (cnt_q != N_CNT) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          idx_d  = cnt_q[IDX_W-1:0];
        end
        if (rd_cand) begin
          best_d  = rd_key;
          found_d = 1'b1;
        end
        if (sweep_done && found_q) begin
          if (rem_q < best_tk_ext) begin
            chosen_d = ~best_q[IDX_W-1:0];
          end else begin
            rem_d   = rem_q - best_tk_ext;
            bound_d = best_q;
            first_d = 1'b0;
            found_d = 1'b0;
            cnt_d   = '0;
          end
        end
      end
      lps_pkg::ST_DONE: begin
        flags_d[chosen_q] = 1'b0;
        running_d         = chosen_q;
        out_valid_d       = 1'b1;
        out_chosen_d      = chosen32[lps_pkg::ID_OUT_W-1:0];
        out_prev_d        = prev_q;
        out_sum_d         = sum32[lps_pkg::SUM_OUT_W-1:0];
        out_status_d      = any_q ? lps_pkg::STAT_DONE : lps_pkg::STAT_EMPTY;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lps_pkg::ST_IDLE;
      flags_q     <= '0;
      stamp_q     <= '0;
      running_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flags_q     <= flags_d;
      stamp_q     <= stamp_d;
      running_q   <= running_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sum_q        <= sum_d;
    any_q        <= any_d;
    rnd_q        <= rnd_d;
    rem_q        <= rem_d;
    mod_cnt_q    <= mod_cnt_d;
    best_q       <= best_d;
    bound_q      <= bound_d;
    found_q      <= found_d;
    first_q      <= first_d;
    chosen_q     <= chosen_d;
    prev_q       <= prev_d;
    out_chosen_q <= out_chosen_d;
    out_prev_q   <= out_prev_d;
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.chosen_id   = out_chosen_q;
  assign rsp_o.previous_id = out_prev_q;
  assign rsp_o.ticket_sum  = out_sum_q;
  assign rsp_o.status      = out_status_q;

endmodule
`default_nettype wire
